[src/dcs_udk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_udk_pkg
// Operation and action codes, character constants and the decode helpers
// used by the DCS user-defined-key parser.
// ----------------------------------------------------------------------------
package dcs_udk_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_ABSORBED = 3'd0,
        ACT_END      = 3'd1,
        ACT_GRAPHICS = 3'd2,
        ACT_CONTROL  = 3'd3,
        ACT_STORED   = 3'd4,
        ACT_CLEARED  = 3'd5,
        ACT_READ     = 3'd6,
        ACT_IGNORED  = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        LOCK_OPEN    = 2'd0,
        LOCK_PENDING = 2'd1,
        LOCK_SET     = 2'd2
    } lock_t;

    localparam int unsigned SLOT_COUNT = 15;
    localparam logic [3:0]  NO_SLOT    = 4'd15;
    localparam logic [15:0] PARAM_MAX  = 16'hFFFF;
    localparam logic [15:0] KEY_FIRST  = 16'd17;
    localparam logic [15:0] KEY_LAST   = 16'd34;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_C0MAX = 8'h1F;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic logic [15:0] decimal_push(input logic [15:0] acc,
                                                 input logic [3:0] digit);
        logic [19:0] v;
        v = {4'd0, acc} * 20'd10 + {16'd0, digit};
        return (v > {4'd0, PARAM_MAX}) ? PARAM_MAX : v[15:0];
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [3:0] key_slot(input logic [4:0] k);
        logic [3:0] s;
        case (k)
            5'd0:    s = 4'd0;
            5'd1:    s = 4'd1;
            5'd2:    s = 4'd2;
            5'd3:    s = 4'd3;
            5'd4:    s = 4'd4;
            5'd6:    s = 4'd5;
            5'd7:    s = 4'd6;
            5'd8:    s = 4'd7;
            5'd9:    s = 4'd8;
            5'd11:   s = 4'd9;
            5'd12:   s = 4'd10;
            5'd14:   s = 4'd11;
            5'd15:   s = 4'd12;
            5'd16:   s = 4'd13;
            5'd17:   s = 4'd14;
            default: s = NO_SLOT;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[src/dcs_udk_sequence_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_udk_sequence_parser
// DCS parser for user-defined keys and ReGIS entry, with key string store.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one request per character or command. s_tuser = op; s_tdata carries
//         data_byte, read_slot and read_offset; one per cycle while s_tready is high.
//   m_* : one result per request, in order. m_tuser action code.
//   cfg_*: graphics_allowed write, accepted in any cycle; write it only while
//         no request is in flight.
// Pipeline: a result passes one register stage for the key store and length
//   memory reads and one for the output queue before it is presented. Sustained
//   rate is one request per clock while s_tready stays high; every parser
//   update and the single key store write complete in the accept cycle.
// The output queue holds three results; s_tready is low only while three
//   results are in flight, so a stalled receiver stops input after at most
//   three further requests and nothing is lost.
// Reset clears parser state and the per-slot length valid bits, so every key
//   reads as undefined at once; there is no clearing pass. Key store contents
//   are undefined until written and are only read below a valid length.
// ----------------------------------------------------------------------------
module dcs_udk_sequence_parser #(
    parameter int unsigned SLOT_BYTES  = 512,
    parameter int unsigned PARAM_SLOTS = 31,
    localparam int unsigned OFF_W  = $clog2(SLOT_BYTES),
    localparam int unsigned IN_W   = ((12 + OFF_W + 7) / 8) * 8,
    localparam int unsigned OUT_W  = ((16 + OFF_W + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,     // graphics_allowed
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,      // data_byte, read_slot, read_offset
    input  wire logic [1:0]        s_tuser,      // op
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,      // graphics_level, control_char,
                                                 // read_data, key_length, keys_locked
    output logic [2:0]             m_tuser       // action
);

    localparam int unsigned IDX_W   = $clog2(PARAM_SLOTS);
    localparam int unsigned DEPTH   = dcs_udk_pkg::SLOT_COUNT * SLOT_BYTES;
    localparam int unsigned ADDR_W  = $clog2(DEPTH);
    localparam int unsigned Q_DEPTH = 3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PARAMS = 2'd1,
        PH_CHOOSE = 2'd2,
        PH_DEFINE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [1:0]       glevel;
        logic [4:0]       ctrl;
        logic [7:0]       rdata;
        logic [OFF_W-1:0] klen;
        logic             locked;
    } result_t;

    typedef struct packed {
        result_t          res;
        logic             is_read;
        logic             slot_ok;
        logic [OFF_W-1:0] roff;
    } stage_t;

    phase_t                 phase_reg, phase_next;
    logic [IDX_W-1:0]       idx_reg, idx_next, idx_inc;
    logic [15:0]            p0_reg, p0_next, p1_reg, p1_next, key_reg, key_next;
    logic [15:0]            push_in, push_out;
    logic [1:0]             lock_reg, lock_next, lock_bar;
    logic [3:0]             slot_reg, slot_next, map_slot;
    logic [OFF_W-1:0]       wpos_reg, wpos_next;
    logic [7:0]             part_reg, part_next, part_new;
    logic                   nib_reg, nib_next;
    logic [1:0]             level_reg, level_next;
    logic                   ga_reg;

    logic                   accept;
    dcs_udk_pkg::hex_t      hex;
    logic [7:0]             c;
    logic [3:0]             rslot;
    logic [OFF_W-1:0]       roff;
    logic                   rslot_ok, digit, cleared;
    logic [2:0]             act, ck;
    logic                   ks_we, len_we, clr_all, clr_one;
    logic [3:0]             clr_slot;
    logic [ADDR_W-1:0]      ks_waddr, ks_raddr;

    logic [7:0]             ks_mem [DEPTH];
    logic [OFF_W-1:0]       len_mem [dcs_udk_pkg::SLOT_COUNT];
    logic [dcs_udk_pkg::SLOT_COUNT-1:0] len_valid_reg;
    logic [7:0]             key_q;
    logic [OFF_W-1:0]       len_q;
    logic                   len_v_q;

    stage_t                 s1_reg, s1_next;
    logic                   s1_valid_reg;
    result_t                s1_res;
    result_t                q_mem [Q_DEPTH];
    logic [1:0]             wr_ptr_reg, rd_ptr_reg, cnt_reg;
    logic                   pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = ({1'b0, cnt_reg} + {2'd0, s1_valid_reg}) < 3'(Q_DEPTH);
    assign accept    = s_tvalid && s_tready;
    assign c         = s_tdata[7:0];
    assign rslot     = s_tdata[11:8];
    assign roff      = s_tdata[12 +: OFF_W];
    assign rslot_ok  = rslot != dcs_udk_pkg::NO_SLOT;
    assign hex       = dcs_udk_pkg::hex_decode(c);
    assign digit     = c inside {[8'h30:8'h39]};
    assign push_in   = (phase_reg == PH_CHOOSE) ? key_reg : ((idx_reg == '0) ? p0_reg : p1_reg);
    assign push_out  = dcs_udk_pkg::decimal_push(push_in, c[3:0]);
    assign map_slot  = dcs_udk_pkg::key_slot(5'(key_reg - dcs_udk_pkg::KEY_FIRST));
    assign part_new  = {part_reg[3:0], hex.value};
    assign ks_waddr  = ADDR_W'(slot_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wpos_reg);
    assign ks_raddr  = rslot_ok ? (ADDR_W'(rslot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(roff))
                                : '0;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        key_next   = key_reg;
        lock_next  = lock_reg;
        slot_next  = slot_reg;
        wpos_next  = wpos_reg;
        part_next  = part_reg;
        nib_next   = nib_reg;
        level_next = level_reg;
        act        = dcs_udk_pkg::ACT_IGNORED;
        ks_we      = 1'b0;
        len_we     = 1'b0;
        clr_all    = 1'b0;
        clr_one    = 1'b0;
        clr_slot   = slot_reg;
        cleared    = 1'b0;
        lock_bar   = lock_reg;
        idx_inc    = idx_reg;
        ck         = dcs_udk_pkg::ACT_ABSORBED;
        if (lock_reg != dcs_udk_pkg::LOCK_SET)
        begin
            ck = (wpos_reg != '0) ? dcs_udk_pkg::ACT_STORED : dcs_udk_pkg::ACT_CLEARED;
        end
        case (s_tuser)
            dcs_udk_pkg::OP_START:
            begin
                phase_next = PH_PARAMS;
                idx_next   = '0;
                p0_next    = '0;
                p1_next    = '0;
                act        = dcs_udk_pkg::ACT_ABSORBED;
            end
            dcs_udk_pkg::OP_BYTE:
            begin
                case (phase_reg)
                    PH_PARAMS:
                    begin
                        act = dcs_udk_pkg::ACT_ABSORBED;
                        if (digit)
                        begin
                            if (idx_reg == '0)
                                p0_next = push_out;
                            else if (idx_reg == IDX_W'(1))
                                p1_next = push_out;
                        end
                        else if (c == dcs_udk_pkg::CH_SEMI)
                        begin
                            if (32'(idx_reg) < PARAM_SLOTS - 1)
                                idx_inc = idx_reg + IDX_W'(1);
                            idx_next = idx_inc;
                            if (idx_inc == IDX_W'(1))
                                p1_next = '0;
                        end
                        else if (c == dcs_udk_pkg::CH_P)
                        begin
                            phase_next = PH_IDLE;
                            if (!ga_reg)
                                act = dcs_udk_pkg::ACT_END;
                            else
                            begin
                                if (p0_reg <= 16'd3)
                                    level_next = p0_reg[1:0];
                                act = dcs_udk_pkg::ACT_GRAPHICS;
                            end
                        end
                        else if (c == dcs_udk_pkg::CH_BAR)
                        begin
                            if (lock_reg == dcs_udk_pkg::LOCK_PENDING)
                                lock_bar = dcs_udk_pkg::LOCK_SET;
                            cleared = (p0_reg == '0) && (lock_bar != dcs_udk_pkg::LOCK_SET);
                            clr_all = cleared;
                            lock_next = lock_bar;
                            if (p1_reg == '0 && lock_bar != dcs_udk_pkg::LOCK_SET)
                                lock_next = dcs_udk_pkg::LOCK_PENDING;
                            key_next   = '0;
                            phase_next = PH_CHOOSE;
                            act = cleared ? dcs_udk_pkg::ACT_CLEARED : dcs_udk_pkg::ACT_ABSORBED;
                        end
                        else if (c != 8'h00 && c <= dcs_udk_pkg::CH_C0MAX)
                        begin
                            act = dcs_udk_pkg::ACT_CONTROL;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            act        = dcs_udk_pkg::ACT_END;
                        end
                    end
                    PH_CHOOSE:
                    begin
                        if (digit)
                        begin
                            key_next = push_out;
                            act      = dcs_udk_pkg::ACT_ABSORBED;
                        end
                        else if (c != dcs_udk_pkg::CH_SLASH || key_reg < dcs_udk_pkg::KEY_FIRST
                                 || key_reg > dcs_udk_pkg::KEY_LAST
                                 || map_slot == dcs_udk_pkg::NO_SLOT)
                        begin
                            phase_next = PH_IDLE;
                            act        = dcs_udk_pkg::ACT_END;
                        end
                        else
                        begin
                            if (lock_reg != dcs_udk_pkg::LOCK_SET)
                            begin
                                slot_next = map_slot;
                                wpos_next = '0;
                                part_next = '0;
                                clr_one   = 1'b1;
                                clr_slot  = map_slot;
                            end
                            nib_next   = 1'b0;
                            phase_next = PH_DEFINE;
                            act        = dcs_udk_pkg::ACT_ABSORBED;
                        end
                    end
                    PH_DEFINE:
                    begin
                        if (hex.ok)
                        begin
                            act = dcs_udk_pkg::ACT_ABSORBED;
                            if (lock_reg != dcs_udk_pkg::LOCK_SET)
                                part_next = part_new;
                            if (nib_reg)
                            begin
                                if (lock_reg != dcs_udk_pkg::LOCK_SET)
                                begin
                                    if (wpos_reg < OFF_W'(SLOT_BYTES - 1))
                                    begin
                                        ks_we     = 1'b1;
                                        wpos_next = wpos_reg + OFF_W'(1);
                                    end
                                    part_next = '0;
                                end
                                nib_next = 1'b0;
                            end
                            else
                            begin
                                nib_next = 1'b1;
                            end
                        end
                        else if (c == dcs_udk_pkg::CH_SEMI)
                        begin
                            len_we     = lock_reg != dcs_udk_pkg::LOCK_SET;
                            key_next   = '0;
                            phase_next = PH_CHOOSE;
                            act        = ck;
                        end
                        else if (c == dcs_udk_pkg::CH_SPACE)
                        begin
                            len_we     = lock_reg != dcs_udk_pkg::LOCK_SET;
                            phase_next = PH_IDLE;
                            if (lock_reg == dcs_udk_pkg::LOCK_PENDING)
                                lock_next = dcs_udk_pkg::LOCK_SET;
                            act = (ck != dcs_udk_pkg::ACT_ABSORBED) ? ck : dcs_udk_pkg::ACT_END;
                        end
                        else
                        begin
                            act = dcs_udk_pkg::ACT_END;
                            if (lock_reg != dcs_udk_pkg::LOCK_SET)
                            begin
                                clr_one = 1'b1;
                                act     = dcs_udk_pkg::ACT_CLEARED;
                            end
                            lock_next  = dcs_udk_pkg::LOCK_SET;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        act = dcs_udk_pkg::ACT_IGNORED;
                    end
                endcase
            end
            dcs_udk_pkg::OP_READ:
            begin
                act = dcs_udk_pkg::ACT_READ;
            end
            default:
            begin
                act = dcs_udk_pkg::ACT_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        s1_next             = '0;
        s1_next.res.action  = act;
        s1_next.res.glevel  = (act == dcs_udk_pkg::ACT_GRAPHICS) ? level_next : 2'd0;
        s1_next.res.ctrl    = (act == dcs_udk_pkg::ACT_CONTROL) ? c[4:0] : 5'd0;
        s1_next.res.locked  = lock_next == dcs_udk_pkg::LOCK_SET;
        s1_next.is_read     = s_tuser == dcs_udk_pkg::OP_READ;
        s1_next.slot_ok     = rslot_ok;
        s1_next.roff        = roff;
    end

    always_comb
    begin
        s1_res       = s1_reg.res;
        s1_res.klen  = (s1_reg.is_read && s1_reg.slot_ok && len_v_q) ? len_q : '0;
        s1_res.rdata = (s1_reg.is_read && s1_reg.slot_ok && len_v_q && s1_reg.roff < len_q)
                       ? key_q : 8'd0;
    end

    // key store and length memory
    always_ff @(posedge clk)
    begin
        if (accept && ks_we)
            ks_mem[ks_waddr] <= part_new;
        if (accept && len_we)
            len_mem[slot_reg] <= wpos_reg;
        if (accept)
        begin
            key_q   <= ks_mem[ks_raddr];
            len_q   <= len_mem[rslot_ok ? rslot : 4'd0];
            len_v_q <= rslot_ok && len_valid_reg[rslot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            q_mem[wr_ptr_reg] <= s1_res;
        if (accept)
            s1_reg <= s1_next;
    end

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            p0_reg        <= '0;
            p1_reg        <= '0;
            key_reg       <= '0;
            lock_reg      <= dcs_udk_pkg::LOCK_OPEN;
            slot_reg      <= '0;
            wpos_reg      <= '0;
            part_reg      <= '0;
            nib_reg       <= 1'b0;
            level_reg     <= '0;
            ga_reg        <= 1'b1;
            len_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ga_reg <= cfg_data;
            if (accept)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                p0_reg    <= p0_next;
                p1_reg    <= p1_next;
                key_reg   <= key_next;
                lock_reg  <= lock_next;
                slot_reg  <= slot_next;
                wpos_reg  <= wpos_next;
                part_reg  <= part_next;
                nib_reg   <= nib_next;
                level_reg <= level_next;
                if (clr_all)
                    len_valid_reg <= '0;
                if (clr_one)
                    len_valid_reg[clr_slot] <= 1'b0;
                if (len_we)
                    len_valid_reg[slot_reg] <= 1'b1;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
                wr_ptr_reg <= (wr_ptr_reg == 2'(Q_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == 2'(Q_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tuser  = q_mem[rd_ptr_reg].action;
    assign m_tdata  = OUT_W'({q_mem[rd_ptr_reg].locked, q_mem[rd_ptr_reg].klen,
                              q_mem[rd_ptr_reg].rdata, q_mem[rd_ptr_reg].ctrl,
                              q_mem[rd_ptr_reg].glevel});

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {2'd0, s1_valid_reg}) <= 3'(Q_DEPTH))
        else $error("result queue overrun");

    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg == dcs_udk_pkg::LOCK_SET |=> lock_reg == dcs_udk_pkg::LOCK_SET)
        else $error("key lock released");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ks_we) |-> (phase_reg == PH_DEFINE && lock_reg != dcs_udk_pkg::LOCK_SET))
        else $error("key store written outside an unlocked definition");

    a_len_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_reg.is_read) |-> (s1_res.klen == '0 && s1_res.rdata == 8'd0))
        else $error("read data on a non-read result");

endmodule
`default_nettype wire
